// ----- src/uer_pkg.sv -----
// ----------------------------------------------------------------------------
// Echo ranger package
// Shared widths, codes and controller/datapath command types.
// ----------------------------------------------------------------------------
package uer_pkg;

    localparam int TIMER_BITS  = 16;
    localparam int SCALE       = 100;
    localparam int SCALE_W     = 7;
    localparam int PROD_W      = TIMER_BITS + SCALE_W;
    localparam int CNT_W       = $clog2(PROD_W);
    localparam int BYTE_W      = 8;
    localparam int DEN_W       = 8;
    localparam int DIGIT_BASE  = 10;
    localparam int CFG_IDX_W   = 8;
    localparam int RECIP_SHIFT = PROD_W + 4;
    localparam int RECIP_W     = PROD_W + 1;
    localparam int TEN_PROD_W  = PROD_W + RECIP_W;

    localparam logic [BYTE_W-1:0] FRAME_HEAD   = 8'hFF;
    localparam logic [DEN_W-1:0]  DIVISOR_RST  = 8'd94;
    localparam logic [BYTE_W-1:0] FAR_CM_RST   = 8'd30;
    localparam logic [BYTE_W-1:0] MID_CM_RST   = 8'd20;
    localparam logic [BYTE_W-1:0] NEAR_CM_RST  = 8'd10;

    // Round the reciprocal of the digit base up so the product floors exactly
    localparam logic [RECIP_W-1:0] RECIP_TEN =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(DIGIT_BASE - 1)) / 64'(DIGIT_BASE));

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DIVISOR = 8'd0,
        CFG_FAR     = 8'd1,
        CFG_MID     = 8'd2,
        CFG_NEAR    = 8'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        SEL_HEAD  = 2'd0,
        SEL_CM    = 2'd1,
        SEL_DIGIT = 2'd2,
        SEL_LEVEL = 2'd3
    } sel_t;

    typedef enum logic [1:0] {
        LEVEL_FAR  = 2'd0,
        LEVEL_MID  = 2'd1,
        LEVEL_NEAR = 2'd2,
        LEVEL_HIT  = 2'd3
    } level_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_DIV_A,
        ST_MUL,
        ST_SPLIT,
        ST_SEND
    } state_t;

    typedef struct packed {
        logic capture_start;
        logic capture_stop;
        logic div_init_a;
        logic ten_mul;
        logic ten_split;
        logic div_step;
        logic out_load;
        sel_t out_sel;
    } cmd_t;

endpackage

// ----- src/uer_in_if.sv -----
// ----------------------------------------------------------------------------
// Echo edge request channel
// Valid/ready channel carrying one edge capture event.
// ----------------------------------------------------------------------------
interface uer_in_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [15:0] capture_time;

    modport source (output valid, output action, output capture_time, input ready);
    modport sink   (input valid, input action, input capture_time, output ready);
endinterface

// ----- src/uer_out_if.sv -----
// ----------------------------------------------------------------------------
// Frame byte channel
// Valid/ready channel carrying one byte of the range frame.
// ----------------------------------------------------------------------------
interface uer_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       last;

    modport source (output valid, output frame_byte, output last, input ready);
    modport sink   (input valid, input frame_byte, input last, output ready);
endinterface

// ----- src/uer_cfg_if.sv -----
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface uer_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] index;
    logic [7:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- src/uer_datapath.sv -----
// ----------------------------------------------------------------------------
// Echo ranger datapath
// Start time, scaled pulse width, restoring divider, reciprocal split by ten,
// config and output byte registers.
// ----------------------------------------------------------------------------
module uer_datapath
    import uer_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cmd_t                  cmd,
    input  logic [TIMER_BITS-1:0] capture_time,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [BYTE_W-1:0]     cfg_data,
    output logic [BYTE_W-1:0]     frame_byte,
    output logic                  last
);

    logic [TIMER_BITS-1:0] start_reg;
    logic [TIMER_BITS-1:0] start_next;
    logic [PROD_W-1:0]     prod_reg;
    logic [PROD_W-1:0]     prod_next;
    logic [PROD_W-1:0]     num_reg;
    logic [PROD_W-1:0]     num_next;
    logic [DEN_W-1:0]      rem_reg;
    logic [DEN_W-1:0]      rem_next;
    logic [DEN_W-1:0]      den_reg;
    logic [DEN_W-1:0]      den_next;
    logic [TEN_PROD_W-1:0] ten_prod_reg;
    logic [TEN_PROD_W-1:0] ten_prod_next;
    logic [BYTE_W-1:0]     byte_reg;
    logic [BYTE_W-1:0]     byte_next;
    logic                  last_reg;
    logic                  last_next;
    logic [DEN_W-1:0]      divisor_reg;
    logic [BYTE_W-1:0]     far_reg;
    logic [BYTE_W-1:0]     mid_reg;
    logic [BYTE_W-1:0]     near_reg;

    logic [TIMER_BITS-1:0] diff;
    logic [DEN_W:0]        trial;
    logic                  fits;
    logic [PROD_W-1:0]     ten_quo;
    logic [PROD_W-1:0]     ten_rem;
    logic [BYTE_W-1:0]     cm_byte;
    level_t                level;

    // Register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            divisor_reg <= DIVISOR_RST;
            far_reg     <= FAR_CM_RST;
            mid_reg     <= MID_CM_RST;
            near_reg    <= NEAR_CM_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_DIVISOR: divisor_reg <= cfg_data;
                CFG_FAR:     far_reg     <= cfg_data;
                CFG_MID:     mid_reg     <= cfg_data;
                CFG_NEAR:    near_reg    <= cfg_data;
                default:     ;
            endcase
        end
    end

    assign diff    = capture_time - start_reg;
    assign trial   = {rem_reg, num_reg[PROD_W-1]};
    assign fits    = trial >= {1'b0, den_reg};
    assign ten_quo = PROD_W'(ten_prod_reg >> RECIP_SHIFT);
    assign ten_rem = num_reg - ten_quo * PROD_W'(DIGIT_BASE);
    assign cm_byte = num_reg[BYTE_W-1:0];

    always_comb
    begin
        priority if (cm_byte > far_reg)
            level = LEVEL_FAR;
        else if (cm_byte > mid_reg)
            level = LEVEL_MID;
        else if (cm_byte > near_reg)
            level = LEVEL_NEAR;
        else
            level = LEVEL_HIT;
    end

    always_comb
    begin
        start_next    = start_reg;
        prod_next     = prod_reg;
        num_next      = num_reg;
        rem_next      = rem_reg;
        den_next      = den_reg;
        ten_prod_next = ten_prod_reg;
        byte_next     = byte_reg;
        last_next     = last_reg;

        if (cmd.capture_start)
            start_next = capture_time;
        if (cmd.capture_stop)
        begin
            start_next = '0;
            prod_next  = PROD_W'(diff) * PROD_W'(SCALE);
        end
        if (cmd.div_init_a)
        begin
            num_next = prod_reg;
            rem_next = '0;
            den_next = (divisor_reg == '0) ? DEN_W'(1) : divisor_reg;
        end
        if (cmd.div_step)
        begin
            num_next = {num_reg[PROD_W-2:0], fits};
            rem_next = fits ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
        end
        if (cmd.ten_mul)
            ten_prod_next = TEN_PROD_W'(num_reg) * TEN_PROD_W'(RECIP_TEN);
        if (cmd.ten_split)
        begin
            num_next = ten_quo;
            rem_next = ten_rem[DEN_W-1:0];
        end
        if (cmd.out_load)
        begin
            last_next = (cmd.out_sel == SEL_LEVEL);
            unique case (cmd.out_sel)
                SEL_HEAD:  byte_next = FRAME_HEAD;
                SEL_CM:    byte_next = cm_byte;
                SEL_DIGIT: byte_next = BYTE_W'(rem_reg);
                SEL_LEVEL: byte_next = BYTE_W'(level);
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= '0;
        end
        else
        begin
            start_reg <= start_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg     <= prod_next;
        num_reg      <= num_next;
        rem_reg      <= rem_next;
        den_reg      <= den_next;
        ten_prod_reg <= ten_prod_next;
        byte_reg     <= byte_next;
        last_reg     <= last_next;
    end

    assign frame_byte = byte_reg;
    assign last       = last_reg;

endmodule

// ----- src/uer_ctrl.sv -----
// ----------------------------------------------------------------------------
// Echo ranger controller
// Edge pairing, divider sequencing and frame byte delivery.
// ----------------------------------------------------------------------------
module uer_ctrl
    import uer_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  logic in_action,
    output logic in_ready,
    output logic out_valid,
    input  logic out_ready,
    output cmd_t cmd
);

    state_t           state_reg;
    state_t           state_next;
    logic             armed_reg;
    logic             armed_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    sel_t             idx_reg;
    sel_t             idx_next;

    logic in_fire;
    logic out_fire;
    logic cnt_done;

    assign in_fire  = in_valid && (state_reg == ST_IDLE);
    assign out_fire = out_ready && (state_reg == ST_SEND);
    assign cnt_done = (cnt_reg == CNT_W'(PROD_W - 1));

    always_comb
    begin
        state_next = state_reg;
        armed_next = armed_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (!in_action && !armed_reg)
                        armed_next = 1'b1;
                    else if (in_action && armed_reg)
                    begin
                        armed_next = 1'b0;
                        state_next = ST_SETUP;
                    end
                end
            end
            ST_SETUP:
            begin
                cnt_next   = '0;
                state_next = ST_DIV_A;
            end
            ST_DIV_A:
            begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_done)
                    state_next = ST_MUL;
            end
            ST_MUL:
            begin
                state_next = ST_SPLIT;
            end
            ST_SPLIT:
            begin
                idx_next   = SEL_HEAD;
                state_next = ST_SEND;
            end
            ST_SEND:
            begin
                if (out_fire)
                begin
                    if (idx_reg == SEL_LEVEL)
                        state_next = ST_IDLE;
                    else
                        idx_next = sel_t'(idx_reg + 2'd1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd           = '0;
        cmd.out_sel   = SEL_HEAD;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.capture_start = in_fire && !in_action && !armed_reg;
                cmd.capture_stop  = in_fire && in_action && armed_reg;
            end
            ST_SETUP:
            begin
                cmd.div_init_a = 1'b1;
            end
            ST_DIV_A:
            begin
                cmd.div_step = 1'b1;
            end
            ST_MUL:
            begin
                cmd.ten_mul = 1'b1;
            end
            ST_SPLIT:
            begin
                cmd.ten_split = 1'b1;
                cmd.out_load  = 1'b1;
                cmd.out_sel   = SEL_HEAD;
            end
            ST_SEND:
            begin
                cmd.out_load = out_fire && (idx_reg != SEL_LEVEL);
                cmd.out_sel  = sel_t'(idx_reg + 2'd1);
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_SEND);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            armed_reg <= 1'b0;
            cnt_reg   <= '0;
            idx_reg   <= SEL_HEAD;
        end
        else
        begin
            state_reg <= state_next;
            armed_reg <= armed_next;
            cnt_reg   <= cnt_next;
            idx_reg   <= idx_next;
        end
    end

endmodule

// ----- src/ultrasonic_echo_ranger_core.sv -----
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger core
// Pairs echo edges, converts pulse width to distance and sends a 4-byte frame.
// ----------------------------------------------------------------------------
// A falling edge that closes a pulse starts a measurement: the scaled width is
// registered at the request, then the setup state loads the divider, a
// 1-bit-per-cycle restoring divider divides by the divisor register, the
// multiply state multiplies by the reciprocal of ten, and the split state
// splits centimeters from the tenth digit while the head byte 0xFF is loaded;
// the frame's four bytes then follow one per accepted cycle. No new edge
// request is taken until the last byte is delivered. Configuration writes are
// taken every cycle.
module ultrasonic_echo_ranger_core
    import uer_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    uer_in_if.sink     in_ch,
    uer_out_if.source  out_ch,
    uer_cfg_if.sink    cfg_ch
);

    cmd_t cmd;

    assign cfg_ch.ready = 1'b1;

    uer_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_action (in_ch.action),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .cmd       (cmd)
    );

    uer_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .capture_time (in_ch.capture_time),
        .cfg_we       (cfg_ch.valid),
        .cfg_index    (cfg_ch.index),
        .cfg_data     (cfg_ch.data),
        .frame_byte   (out_ch.frame_byte),
        .last         (out_ch.last)
    );

endmodule

// ----- src/uer_checker.sv -----
// ----------------------------------------------------------------------------
// Echo ranger port checker
// Frame shape and handshake checks seen at the core's ports.
// ----------------------------------------------------------------------------
module uer_checker
    import uer_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input logic [BYTE_W-1:0] frame_byte,
    input logic              last
);

    property p_out_hold;
        @(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(frame_byte) && $stable(last);
    endproperty

    property p_one_side;
        @(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid);
    endproperty

    property p_head_first;
        @(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> (frame_byte == FRAME_HEAD) && !last;
    endproperty

    property p_frame_end;
        @(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && last |=> !out_valid && in_ready;
    endproperty

    property p_level_range;
        @(posedge clk) disable iff (!rst_n)
        out_valid && last |-> (frame_byte[BYTE_W-1:2] == '0);
    endproperty

    a_out_hold:    assert property (p_out_hold)    else $error("frame byte dropped while stalled");
    a_one_side:    assert property (p_one_side)    else $error("request taken during frame");
    a_head_first:  assert property (p_head_first)  else $error("frame does not open with head");
    a_frame_end:   assert property (p_frame_end)   else $error("core not idle after frame");
    a_level_range: assert property (p_level_range) else $error("level byte out of range");

endmodule

bind ultrasonic_echo_ranger_core uer_checker u_uer_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .frame_byte (out_ch.frame_byte),
    .last       (out_ch.last)
);
